// File: rtl/core/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants of the double-ended queue
// Command kinds, result status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int VALUE_W          = 32;
  localparam int KIND_W           = 3;
  localparam int STATUS_W         = 2;

  typedef enum logic [KIND_W-1:0] {
    K_PUSH_FRONT = 3'd0,
    K_PUSH_BACK  = 3'd1,
    K_POP_FRONT  = 3'd2,
    K_POP_BACK   = 3'd3,
    K_LIST_FWD   = 3'd4,
    K_LIST_BWD   = 3'd5
  } dq_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } dq_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_LIST
  } dq_state_t;

  // controller -> datapath
  typedef struct packed {
    logic       push_front;
    logic       push_back;
    logic       pop_front;
    logic       pop_back;
    logic       list_start;
    logic       list_step;
    logic       list_fwd;   // direction, sampled with list_start
    logic       emit_imm;   // result with no stored value
    logic       emit_rd;    // result carrying the read-back value
    logic       emit_last;
    dq_status_t status;     // status for emit_imm
  } dq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic list_last;
    logic out_free;
  } dq_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl: command sequencer
// Decodes each accepted word and steers the datapath through pushes,
// pops and listings.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic [dq_pkg::KIND_W-1:0]   in_kind,
  output logic                             in_ready,
  input  wire dq_pkg::dq_stat_t            stat,
  output dq_pkg::dq_cmd_t                  cmd
);

  dq_pkg::dq_state_t state;
  dq_pkg::dq_state_t state_next;
  logic              acc;

  assign acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dq_pkg::S_IDLE: begin
        if (acc && !stat.empty) begin
          case (in_kind)
            dq_pkg::K_POP_FRONT, dq_pkg::K_POP_BACK: state_next = dq_pkg::S_POP;
            dq_pkg::K_LIST_FWD, dq_pkg::K_LIST_BWD:  state_next = dq_pkg::S_LIST;
            default:                                 state_next = dq_pkg::S_IDLE;
          endcase
        end
      end
      dq_pkg::S_POP: begin
        if (stat.out_free) state_next = dq_pkg::S_IDLE;
      end
      dq_pkg::S_LIST: begin
        if (stat.out_free && stat.list_last) state_next = dq_pkg::S_IDLE;
      end
      default: state_next = dq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      dq_pkg::S_IDLE: begin
        in_ready = stat.out_free;
        if (acc) begin
          case (in_kind)
            dq_pkg::K_PUSH_FRONT, dq_pkg::K_PUSH_BACK: begin
              cmd.emit_imm  = 1'b1;
              cmd.emit_last = 1'b1;
              if (stat.full) begin
                cmd.status = dq_pkg::ST_FULL;
              end else begin
                cmd.status     = dq_pkg::ST_OK;
                cmd.push_front = (in_kind == dq_pkg::K_PUSH_FRONT);
                cmd.push_back  = (in_kind == dq_pkg::K_PUSH_BACK);
              end
            end
            dq_pkg::K_POP_FRONT, dq_pkg::K_POP_BACK: begin
              if (stat.empty) begin
                cmd.emit_imm  = 1'b1;
                cmd.emit_last = 1'b1;
                cmd.status    = dq_pkg::ST_EMPTY;
              end else begin
                cmd.pop_front = (in_kind == dq_pkg::K_POP_FRONT);
                cmd.pop_back  = (in_kind == dq_pkg::K_POP_BACK);
              end
            end
            dq_pkg::K_LIST_FWD, dq_pkg::K_LIST_BWD: begin
              if (stat.empty) begin
                cmd.emit_imm  = 1'b1;
                cmd.emit_last = 1'b1;
                cmd.status    = dq_pkg::ST_EMPTY;
              end else begin
                cmd.list_start = 1'b1;
                cmd.list_fwd   = (in_kind == dq_pkg::K_LIST_FWD);
              end
            end
            default: ; // unused codes are dropped silently
          endcase
        end
      end
      dq_pkg::S_POP: begin
        if (stat.out_free) begin
          cmd.emit_rd   = 1'b1;
          cmd.emit_last = 1'b1;
        end
      end
      dq_pkg::S_LIST: begin
        if (stat.out_free) begin
          cmd.emit_rd   = 1'b1;
          cmd.emit_last = stat.list_last;
          cmd.list_step = !stat.list_last;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/dq_dpath.sv
// ----------------------------------------------------------------------------
// dq_dpath: queue storage and pointers
// Circular entry memory with registered read, front position, entry count,
// listing index and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_dpath #(
  parameter int CAPACITY = dq_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dq_pkg::dq_cmd_t               cmd,
  output dq_pkg::dq_stat_t                   stat,
  input  wire logic [dq_pkg::VALUE_W-1:0]    in_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [dq_pkg::STATUS_W-1:0]        out_status,
  output logic [dq_pkg::VALUE_W-1:0]         out_item,
  output logic                               out_last
);

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [dq_pkg::VALUE_W-1:0] mem [CAPACITY];
  logic [dq_pkg::VALUE_W-1:0] rd_data;

  logic [PW-1:0] front;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic          list_fwd;

  logic [CW-1:0] k_sel;
  logic [CW:0]   slot_sum;
  logic [PW-1:0] slot;
  logic [PW-1:0] front_dec;
  logic [PW-1:0] front_inc;
  logic [PW-1:0] addr;
  logic          rd_en;
  logic          push;

  // offset from the front of the entry touched this cycle
  always_comb begin
    k_sel = '0;
    if (cmd.push_back) begin
      k_sel = count;
    end else if (cmd.pop_back || (cmd.list_start && !cmd.list_fwd)) begin
      k_sel = count - CW'(1);
    end else if (cmd.list_step) begin
      k_sel = list_fwd ? (idx + CW'(1)) : (count - CW'(2) - idx);
    end
  end

  // front plus offset stays below 2*CAPACITY, so one subtract wraps it
  assign slot_sum  = (CW+1)'(front) + (CW+1)'(k_sel);
  assign slot      = (slot_sum >= (CW+1)'(CAPACITY)) ?
                     PW'(slot_sum - (CW+1)'(CAPACITY)) : PW'(slot_sum);
  assign front_dec = (front == '0) ? PW'(CAPACITY - 1) : front - PW'(1);
  assign front_inc = (front == PW'(CAPACITY - 1)) ? '0 : front + PW'(1);
  assign addr      = cmd.push_front ? front_dec : slot;
  assign push      = cmd.push_front || cmd.push_back;
  assign rd_en     = cmd.pop_front || cmd.pop_back || cmd.list_start || cmd.list_step;

  always_ff @(posedge clk) begin
    if (push) mem[addr] <= in_value;
    if (rd_en) rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front    <= '0;
      count    <= '0;
      idx      <= '0;
      list_fwd <= 1'b0;
    end else begin
      if (cmd.push_front) front <= front_dec;
      if (cmd.pop_front)  front <= front_inc;
      if (push) count <= count + CW'(1);
      if (cmd.pop_front || cmd.pop_back) count <= count - CW'(1);
      if (cmd.list_start) begin
        idx      <= '0;
        list_fwd <= cmd.list_fwd;
      end else if (cmd.list_step) begin
        idx <= idx + CW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_imm || cmd.emit_rd) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_imm) begin
      out_status <= cmd.status;
      out_item   <= '0;
      out_last   <= cmd.emit_last;
    end else if (cmd.emit_rd) begin
      out_status <= dq_pkg::ST_OK;
      out_item   <= rd_data;
      out_last   <= cmd.emit_last;
    end
  end

  assign stat.empty     = (count == '0);
  assign stat.full      = (count == CW'(CAPACITY));
  assign stat.list_last = ((CW+1)'(idx) + (CW+1)'(1) == (CW+1)'(count));
  assign stat.out_free  = !out_valid || out_ready;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_front_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(front) < CW'(CAPACITY))
    else $error("front position out of range");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.push_front || cmd.push_back) |-> !stat.full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop_front || cmd.pop_back || cmd.list_start) |-> !stat.empty)
    else $error("read from empty queue");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_imm || cmd.emit_rd) |-> stat.out_free)
    else $error("result register overwritten");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.push_front || cmd.push_back) |=> (count == $past(count) + CW'(1)))
    else $error("push did not grow count");
`endif

endmodule

`default_nettype wire

// File: rtl/core/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top: bounded double-ended queue of signed 32-bit words
// Push/pop at either end, forward and backward listings over a circular
// store of CAPACITY entries.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata          | tuser              | tlast
//  s_axis   | in  | [31:0] value   | [2:0] kind         | -
//  m_axis   | out | [31:0] item    | [1:0] status       | last
//
//  Push, or any command meeting a full/empty queue: result in the output
//  register the next cycle.
//  Pop: a registered memory read, then into the output register once free.
//  Listing: one memory read per entry, each passed on once the register is free.
//  A new word is taken once the previous command is finished and the output
//  register is free or draining; a stalled m_axis holds the sequencer.
//  Synchronous reset empties the queue at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_top #(
  parameter int CAPACITY = dq_pkg::DEFAULT_CAPACITY
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [dq_pkg::VALUE_W-1:0]   s_axis_tdata,  // [31:0] value
  input  wire logic [dq_pkg::KIND_W-1:0]    s_axis_tuser,  // [2:0] kind
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [dq_pkg::VALUE_W-1:0]        m_axis_tdata,  // [31:0] item
  output logic [dq_pkg::STATUS_W-1:0]       m_axis_tuser,  // [1:0] status
  output logic                              m_axis_tlast
);

  dq_pkg::dq_cmd_t  cmd;
  dq_pkg::dq_stat_t stat;

  dq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_kind  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_value   (s_axis_tdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (m_axis_tuser),
    .out_item   (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

endmodule

`default_nettype wire

// File: tb/deque_tb_pkg.sv
// ----------------------------------------------------------------------------
// deque_tb_pkg: shadow copy of the double-ended queue for the testbench
// Keeps its own circular store, front position and occupancy, works out
// the result words each command should produce and checks the words that
// come back, oldest first.
// ----------------------------------------------------------------------------
`default_nettype none

package deque_tb_pkg;

  import dq_pkg::*;

  localparam int DEPTH = DEFAULT_CAPACITY;

  // codes the block must ignore
  localparam logic [KIND_W-1:0] K_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0] K_SPARE_7 = 3'd7;

  typedef struct {
    dq_status_t           status;
    logic [VALUE_W-1:0]   item;
    logic                 last;
  } deque_result_t;

  class deque_shadow;
    logic [VALUE_W-1:0] slots [DEPTH];
    int                 front_pos;
    int                 occupancy;
    deque_result_t      due [$];
    int                 mismatches;
    int                 commands_taken;
    int                 words_seen;
    int                 full_hits;
    int                 empty_hits;
    int                 longest_listing;

    function new();
      front_pos       = 0;
      occupancy       = 0;
      mismatches      = 0;
      commands_taken  = 0;
      words_seen      = 0;
      full_hits       = 0;
      empty_hits      = 0;
      longest_listing = 0;
    endfunction

    // physical slot of the k-th entry counted from the front
    function int slot_of(int k);
      return (front_pos + k) % DEPTH;
    endfunction

    function void add_due(dq_status_t status, logic [VALUE_W-1:0] item, logic last);
      deque_result_t r;
      r.status = status;
      r.item   = item;
      r.last   = last;
      due.push_back(r);
    endfunction

    function void note_command(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value);
      int pos;
      commands_taken++;
      case (kind)
        K_PUSH_FRONT, K_PUSH_BACK: begin
          if (occupancy >= DEPTH) begin
            full_hits++;
            add_due(ST_FULL, '0, 1'b1);
          end else begin
            if (kind == K_PUSH_FRONT) begin
              front_pos = (front_pos + DEPTH - 1) % DEPTH;
              slots[front_pos] = value;
            end else begin
              slots[slot_of(occupancy)] = value;
            end
            occupancy++;
            add_due(ST_OK, '0, 1'b1);
          end
        end
        K_POP_FRONT, K_POP_BACK: begin
          if (occupancy == 0) begin
            empty_hits++;
            add_due(ST_EMPTY, '0, 1'b1);
          end else begin
            if (kind == K_POP_FRONT) begin
              pos = front_pos;
              front_pos = slot_of(1);
            end else begin
              pos = slot_of(occupancy - 1);
            end
            occupancy--;
            add_due(ST_OK, slots[pos], 1'b1);
          end
        end
        K_LIST_FWD, K_LIST_BWD: begin
          if (occupancy == 0) begin
            empty_hits++;
            add_due(ST_EMPTY, '0, 1'b1);
          end else begin
            if (occupancy > longest_listing) longest_listing = occupancy;
            for (int k = 0; k < occupancy; k++) begin
              pos = (kind == K_LIST_FWD) ? slot_of(k) : slot_of(occupancy - 1 - k);
              add_due(ST_OK, slots[pos], (k + 1 == occupancy));
            end
          end
        end
        default: ;  // spare codes: no word out, state untouched
      endcase
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [VALUE_W-1:0] item,
                               logic last);
      deque_result_t r;
      words_seen++;
      if (due.size() == 0) begin
        $error("unexpected result word: status %0d item %0d last %b",
               status, $signed(item), last);
        mismatches++;
        return;
      end
      r = due.pop_front();
      if (status !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, status);
        mismatches++;
      end
      if (item !== r.item) begin
        $error("item: expected %0d, got %0d", $signed(r.item), $signed(item));
        mismatches++;
      end
      if (last !== r.last) begin
        $error("last: expected %b, got %b", r.last, last);
        mismatches++;
      end
    endfunction
  endclass

endpackage

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the double-ended queue
// Drives command words (push/pop at either end, listings, spare codes) into
// the block, mirrors every accepted word in a shadow queue and checks each
// result word field by field. Directed corner cases first, then random
// traffic that swings between filling and draining, under varying
// backpressure on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  import dq_pkg::*;
  import deque_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PER_PHASE = 114;
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [VALUE_W-1:0]   s_axis_tdata = '0;   // [31:0] value
  logic [KIND_W-1:0]    s_axis_tuser = '0;   // [2:0] kind
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [VALUE_W-1:0]   m_axis_tdata;        // [31:0] item
  logic [STATUS_W-1:0]  m_axis_tuser;        // [1:0] status
  logic                 m_axis_tlast;

  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  int                   cycle_count = 0;
  deque_shadow          shadow;

  logic [VALUE_W-1:0]   corner_vals [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};

  double_ended_queue_top #(.CAPACITY(DEPTH)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      shadow.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
  end

  // one command word; tvalid stays high straight into the next word unless that word draws idle gaps
  task automatic send_command(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= value;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    shadow.note_command(kind, value);
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d result words still due",
             cycle_count, shadow.due.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int                  mode;
    int                  mode_left;
    int                  push_cut;
    int                  roll;
    logic [KIND_W-1:0]   kind;
    logic [VALUE_W-1:0]  value;

    shadow = new();
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // empty queue, spare codes
    send_command(K_POP_FRONT, $urandom);
    send_command(K_POP_BACK, $urandom);
    send_command(K_LIST_FWD, $urandom);
    send_command(K_LIST_BWD, $urandom);
    send_command(K_SPARE_6, $urandom);
    send_command(K_SPARE_7, $urandom);
    // extreme values at both ends
    send_command(K_PUSH_FRONT, 32'h7fff_ffff);
    send_command(K_PUSH_BACK, 32'h8000_0000);
    send_command(K_PUSH_FRONT, 32'h0);
    send_command(K_PUSH_BACK, 32'hffff_ffff);
    // fill up, wrapping the front round the store
    for (int i = 0; i < DEPTH - 4; i++)
      send_command((i % 2) ? K_PUSH_BACK : K_PUSH_FRONT, $urandom);
    send_command(K_PUSH_FRONT, $urandom);
    send_command(K_PUSH_BACK, $urandom);
    send_command(K_LIST_FWD, $urandom);
    send_command(K_LIST_BWD, $urandom);
    send_command(K_POP_FRONT, $urandom);
    send_command(K_POP_BACK, $urandom);

    mode_left = 0;
    mode = MODE_MIXED;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 31; recv_idle_pct = 83; end
        1: begin send_idle_pct = 83; recv_idle_pct = 31; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (mode_left == 0) begin
          mode = $urandom_range(MODE_MIXED, MODE_FILL);
          mode_left = $urandom_range(40, 15);
        end
        mode_left--;
        case (mode)
          MODE_FILL:  push_cut = 75;
          MODE_DRAIN: push_cut = 15;
          default:    push_cut = 45;
        endcase
        roll = $urandom_range(99);
        if (roll < push_cut)
          kind = $urandom_range(1) ? K_PUSH_BACK : K_PUSH_FRONT;
        else if (roll < 85)
          kind = $urandom_range(1) ? K_POP_BACK : K_POP_FRONT;
        else if (roll < 97)
          kind = $urandom_range(1) ? K_LIST_BWD : K_LIST_FWD;
        else
          kind = $urandom_range(1) ? K_SPARE_7 : K_SPARE_6;
        value = ($urandom_range(7) == 0) ? corner_vals[$urandom_range(3)] : $urandom;
        send_command(kind, value);
      end
    end

    @(negedge clk) s_axis_tvalid <= 1'b0;
    while (shadow.due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("%0d commands taken, %0d result words checked in %0d cycles",
             shadow.commands_taken, shadow.words_seen, cycle_count);
    $display("full rejections %0d, empty replies %0d, longest listing %0d entries",
             shadow.full_hits, shadow.empty_hits, shadow.longest_listing);
    if (shadow.mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
